/* src/stb_pkg.sv */
package stb_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  timer_id;
        logic [31:0] period;
        logic        auto_reload;
        logic [30:0] last_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        timer_done;
        logic [7:0]  expired_mask;
        logic [30:0] run_time;
        logic [30:0] elapsed;
    } t_out_item;

    typedef struct packed {
        logic [31:0] cnt;
        logic [31:0] reload;
        logic        autor;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EXEC
    } t_state;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_CREATE  = 3'd1;
    localparam logic [2:0] MODE_DELETE  = 3'd2;
    localparam logic [2:0] MODE_CHECK   = 3'd3;
    localparam logic [2:0] MODE_ELAPSED = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_IN_USE  = 2'd1;
    localparam logic [1:0] STAT_NOT_USE = 2'd2;
    localparam logic [1:0] STAT_RANGE   = 2'd3;

    localparam logic [30:0] UPTIME_WRAP = 31'h7fffffff;

endpackage

/* src/stb_ram.sv */
module stb_ram
    import stb_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/stb_ctrl.sv */
module stb_ctrl
    import stb_pkg::*;
#(
    parameter int TIMER_COUNT = 8,
    parameter int AW          = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in_item      i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_out_item     o_out,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output t_entry        o_wdata,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    input  t_entry        i_rdata
);

    localparam logic [AW-1:0] LAST = AW'(TIMER_COUNT - 1);

    t_state                 r_state, n_state;
    t_in_item               r_item, n_item;
    logic [30:0]            r_uptime, n_uptime;
    logic [TIMER_COUNT-1:0] r_in_use, n_in_use;
    logic [TIMER_COUNT-1:0] r_done, n_done;
    logic [AW-1:0]          r_idx, n_idx;
    logic [AW-1:0]          r_widx, n_widx;
    logic                   r_pend, n_pend;
    logic                   r_rd_end, n_rd_end;
    logic [7:0]             r_mask, n_mask;
    t_out_item              r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    logic [31:0]   up_inc;
    logic [30:0]   up_next;
    logic [31:0]   dec_cnt;
    t_entry        entry_upd;
    logic [5:0]    widx_ext;
    logic [7:0]    hit_bit;
    logic [AW-1:0] tidx;
    logic          in_range;
    t_out_item     res;

    assign up_inc   = {1'b0, r_uptime} + 32'd1;
    assign up_next  = (up_inc[30:0] == UPTIME_WRAP) ? 31'd0 : up_inc[30:0];
    assign dec_cnt  = i_rdata.cnt - 32'd1;
    assign widx_ext = 6'(r_widx);
    assign hit_bit  = (widx_ext < 6'd8) ? (8'd1 << widx_ext[2:0]) : 8'd0;
    assign tidx     = r_item.timer_id[AW-1:0];
    assign in_range = {1'b0, r_item.timer_id} < 9'(TIMER_COUNT);

    always_comb begin
        entry_upd     = i_rdata;
        entry_upd.cnt = dec_cnt;
        if (dec_cnt == 32'd0 && i_rdata.autor) begin
            entry_upd.cnt = i_rdata.reload;
        end
    end

    always_comb begin
        res          = '0;
        res.run_time = r_uptime;
        case (r_item.mode)
            MODE_TICK: begin
                res.expired_mask = r_mask;
            end
            MODE_CREATE: begin
                if (!in_range) begin
                    res.status = STAT_RANGE;
                end else if (r_in_use[tidx]) begin
                    res.status = STAT_IN_USE;
                end
            end
            MODE_DELETE: begin
                if (!in_range) begin
                    res.status = STAT_RANGE;
                end else if (!r_in_use[tidx]) begin
                    res.status = STAT_NOT_USE;
                end
            end
            MODE_CHECK: begin
                if (!in_range) begin
                    res.status = STAT_RANGE;
                end else if (!r_in_use[tidx]) begin
                    res.status = STAT_NOT_USE;
                end else begin
                    res.timer_done = r_done[tidx];
                end
            end
            MODE_ELAPSED: begin
                if (r_uptime >= r_item.last_time) begin
                    res.elapsed = r_uptime - r_item.last_time;
                end else begin
                    res.elapsed = (UPTIME_WRAP - r_item.last_time) + r_uptime;
                end
            end
            default: begin
                res.status = STAT_OK;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_uptime    = r_uptime;
        n_in_use    = r_in_use;
        n_done      = r_done;
        n_idx       = r_idx;
        n_widx      = r_widx;
        n_pend      = 1'b0;
        n_rd_end    = r_rd_end;
        n_mask      = r_mask;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_we        = 1'b0;
        o_waddr     = tidx;
        o_wdata     = '{cnt: r_item.period, reload: r_item.period, autor: r_item.auto_reload};
        o_re        = 1'b0;
        o_raddr     = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in;
                    if (i_in.mode == MODE_TICK) begin
                        n_uptime = up_next;
                        n_idx    = '0;
                        n_rd_end = 1'b0;
                        n_mask   = '0;
                        n_state  = ST_SWEEP;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_SWEEP: begin
                if (!r_rd_end) begin
                    o_re   = 1'b1;
                    n_pend = 1'b1;
                    n_widx = r_idx;
                    if (r_idx == LAST) begin
                        n_rd_end = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                // entries without a used mark are skipped
                if (r_pend && r_in_use[r_widx] && i_rdata.cnt != 32'd0) begin
                    o_we    = 1'b1;
                    o_waddr = r_widx;
                    o_wdata = entry_upd;
                    if (dec_cnt == 32'd0) begin
                        n_done[r_widx] = 1'b1;
                        n_mask         = r_mask | hit_bit;
                    end
                end
                if (r_rd_end && r_pend) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!n_out_valid) begin
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (in_range && r_item.mode == MODE_CREATE && !r_in_use[tidx]) begin
                        o_we           = 1'b1;
                        n_in_use[tidx] = 1'b1;
                        n_done[tidx]   = 1'b0;
                    end
                    if (in_range && r_item.mode == MODE_DELETE && r_in_use[tidx]) begin
                        n_in_use[tidx] = 1'b0;
                        n_done[tidx]   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_uptime    <= '0;
            r_in_use    <= '0;
            r_done      <= '0;
            r_pend      <= 1'b0;
            r_rd_end    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_uptime    <= n_uptime;
            r_in_use    <= n_in_use;
            r_done      <= n_done;
            r_pend      <= n_pend;
            r_rd_end    <= n_rd_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_idx  <= n_idx;
        r_widx <= n_widx;
        r_mask <= n_mask;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* src/software_timer_bank.sv */
// Bank of TIMER_COUNT software timers plus a 31-bit uptime counter that wraps
// to zero at 0x7fffffff. Counts, reload values and reload modes sit in one
// single-port-per-direction memory; used marks and done flags are flops. A
// tick item visits one memory entry per cycle (read, decrement, write back)
// in the sweep state and then goes to the exec state; create, delete, check
// and elapsed items go straight to exec. One item is worked on at a time. The
// result register holds a finished item while the next one is accepted. Only
// timers 0 to 7 have a bit in expired_mask; higher ones still count.
module software_timer_bank
    import stb_pkg::*;
#(
    parameter int TIMER_COUNT = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_rdata;

    stb_ram #(
        .DEPTH (TIMER_COUNT),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    stb_ctrl #(
        .TIMER_COUNT (TIMER_COUNT),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_re        (ram_re),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata)
    );

`ifndef SYNTHESIS
    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("read and write hit the same entry");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> o_in_stall)
        else $error("memory written while idle");

    a_uptime_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.run_time != UPTIME_WRAP)
        else $error("uptime reached wrap value");

    a_mask_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.expired_mask != 8'd0 |->
            o_out.status == STAT_OK && o_out.elapsed == 31'd0 && !o_out.timer_done)
        else $error("expiry mask mixed with other results");
`endif

endmodule
